### src/xs96_pkg.sv
// Shared types and constants for the xorshift96 ranged random block.
`default_nettype none
package xs96_pkg;

  // Generator word width and seeds
  localparam int XS_WORD_W = 32;
  localparam int XS_SPAN_W = XS_WORD_W + 1;
  localparam int XS_CNT_W  = $clog2(XS_WORD_W);
  localparam logic [XS_WORD_W-1:0] XS_SEED_A = 32'd123456789;
  localparam logic [XS_WORD_W-1:0] XS_SEED_B = 32'd362436069;
  localparam logic [XS_WORD_W-1:0] XS_SEED_C = 32'd521288629;

  // Xorshift shift amounts
  localparam int XS_SHL_A = 16;
  localparam int XS_SHR_B = 5;
  localparam int XS_SHL_C = 1;

  // Default depth of the queue between front and back
  localparam int XS_QUEUE_DEPTH = 2;

  // One classified request waiting for the remainder unit
  typedef struct packed {
    logic [XS_WORD_W-1:0] rnd;
    logic [XS_SPAN_W-1:0] span;
    logic [XS_WORD_W-1:0] lower;
    logic                 err;
  } xs96_entry_t;

  // Queue status toward the front, the back and the checks
  typedef struct packed {
    logic full;
    logic empty;
  } xs96_q_stat_t;

  // Back status toward the checks
  typedef struct packed {
    logic busy;
    logic done;
  } xs96_bk_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } xs96_state_t;

endpackage
`default_nettype wire

### src/xs96_front.sv
// Front part: accepts requests, advances the generator and classifies bounds.
`default_nettype none
module xs96_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [63:0]          in_tdata,
  input  wire xs96_pkg::xs96_q_stat_t q_stat,
  output logic                      push,
  output xs96_pkg::xs96_entry_t     push_entry
);
  import xs96_pkg::*;

  logic [XS_WORD_W-1:0] word_a_r, word_b_r, word_c_r;
  logic [XS_WORD_W-1:0] word_a_nxt, word_b_nxt, word_c_nxt;
  logic [XS_WORD_W-1:0] s1, s2, s3;
  logic [XS_WORD_W-1:0] lo, hi, diff;
  logic                 accept;

  // Take an item whenever the queue has room
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept;

  assign lo = in_tdata[31:0];
  assign hi = in_tdata[63:32];

  // Advance the xorshift state by one step
  always_comb begin
    s1 = word_a_r ^ (word_a_r << XS_SHL_A);
    s2 = s1 ^ (s1 >> XS_SHR_B);
    s3 = s2 ^ (s2 << XS_SHL_C);
    word_a_nxt = word_b_r;
    word_b_nxt = word_c_r;
    word_c_nxt = s3 ^ word_b_r ^ word_c_r;
  end

  // Classify the bounds and form the span
  always_comb begin
    diff            = hi - lo;
    push_entry.rnd  = word_c_nxt;
    push_entry.err  = $signed(hi) < $signed(lo);
    push_entry.span = {1'b0, diff} + XS_SPAN_W'(1);
    push_entry.lower = lo;
  end

  // Hold the generator state; advance on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_a_r <= XS_SEED_A;
      word_b_r <= XS_SEED_B;
      word_c_r <= XS_SEED_C;
    end else if (accept) begin
      word_a_r <= word_a_nxt;
      word_b_r <= word_b_nxt;
      word_c_r <= word_c_nxt;
    end
  end

endmodule
`default_nettype wire

### src/xs96_fifo.sv
// Short queue of classified requests between front and back.
`default_nettype none
module xs96_fifo #(
  parameter int DEPTH = xs96_pkg::XS_QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire xs96_pkg::xs96_entry_t push_entry,
  input  wire logic                  pop,
  output xs96_pkg::xs96_entry_t      head,
  output xs96_pkg::xs96_q_stat_t     stat
);
  import xs96_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  xs96_entry_t      slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat.full  = count_r == CNT_W'(DEPTH);
  assign stat.empty = count_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slots_r[rd_ptr_r];

  // Advance pointers with wrap and track the fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries; no reset needed on payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

### src/xs96_back.sv
// Back part: restoring remainder unit, offset add and output register.
`default_nettype none
module xs96_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire xs96_pkg::xs96_q_stat_t q_stat,
  input  wire xs96_pkg::xs96_entry_t head,
  output logic                       pop,
  output xs96_pkg::xs96_bk_stat_t    stat,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [31:0]                out_tdata,
  output logic                       out_tuser
);
  import xs96_pkg::*;

  xs96_state_t          state_r, state_nxt;
  logic [XS_SPAN_W-1:0] rem_r, rem_nxt;
  logic [XS_WORD_W-1:0] quo_r, quo_nxt;
  logic [XS_SPAN_W-1:0] span_r, span_nxt;
  logic [XS_WORD_W-1:0] lower_r, lower_nxt;
  logic                 err_r, err_nxt;
  logic [XS_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [XS_WORD_W-1:0] out_value_r, out_value_nxt;
  logic                 out_err_r, out_err_nxt;
  logic [XS_SPAN_W:0]   trial, trial_diff;
  logic                 load_out;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_err_r;
  assign stat.busy  = state_r != ST_IDLE;
  assign stat.done  = state_r == ST_DONE;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial      = {rem_r, quo_r[XS_WORD_W-1]};
    trial_diff = trial - {1'b0, span_r};
  end

  // Sequence pop, remainder steps and result load
  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    span_nxt      = span_r;
    lower_nxt     = lower_r;
    err_nxt       = err_r;
    cnt_nxt       = cnt_r;
    pop           = 1'b0;
    load_out      = 1'b0;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          rem_nxt   = '0;
          quo_nxt   = head.rnd;
          span_nxt  = head.span;
          lower_nxt = head.lower;
          err_nxt   = head.err;
          cnt_nxt   = XS_CNT_W'(XS_WORD_W - 1);
          // inverted bounds skip the remainder; zero remainder yields lower
          state_nxt = head.err ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = trial_diff[XS_SPAN_W] ? trial[XS_SPAN_W-1:0]
                                         : trial_diff[XS_SPAN_W-1:0];
        quo_nxt = quo_r << 1;
        cnt_nxt = cnt_r - XS_CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out      = 1'b1;
          out_value_nxt = rem_r[XS_WORD_W-1:0] + lower_r;
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers; no reset needed
  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    span_r      <= span_nxt;
    lower_r     <= lower_nxt;
    err_r       <= err_nxt;
    cnt_r       <= cnt_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

endmodule
`default_nettype wire

### src/xorshift96_ranged_random_top.sv
// Ranged xorshift96 random source: front, request queue and remainder back end.
// The back end takes one item at a time from the queue into its bit-serial remainder unit:
// it pops the item, runs 32 restoring steps and loads the result, and takes no new item
// until that load is done. Inverted bounds skip the restoring steps.
// The queue takes up to QUEUE_DEPTH items ahead while the back end works.
// Reset: synchronous active-low rst_n reloads the generator seeds and empties all.
`default_nettype none
module xorshift96_ranged_random_top #(
  parameter int QUEUE_DEPTH = xs96_pkg::XS_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] lower_bound, [63:32] upper_bound
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] value
  output logic             out_tuser   // [0] range_error
);
  import xs96_pkg::*;

  xs96_q_stat_t  q_stat;
  xs96_bk_stat_t bk_stat;
  xs96_entry_t   push_entry, head;
  logic          push, pop;

  xs96_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  xs96_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  xs96_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head       (head),
    .pop        (pop),
    .stat       (bk_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Checks
  a_reset_no_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_tready)
    else $error("input taken while queue full");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(bk_stat.done))
    else $error("result appeared without a finished item");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !bk_stat.busy && !q_stat.empty)
    else $error("queue popped while back end busy or queue empty");

endmodule
`default_nettype wire

### sim/xorshift96_ranged_random_top_tb.sv
// Testbench for the ranged xorshift96 random source: directed bounds, random bounds, scoreboard.
`default_nettype none
module xorshift96_ranged_random_top_tb;

  localparam logic [31:0] SEED_X     = 32'd123456789;
  localparam logic [31:0] SEED_Y     = 32'd362436069;
  localparam logic [31:0] SEED_Z     = 32'd521288629;
  localparam logic [31:0] MOST_NEG   = 32'h8000_0000;
  localparam logic [31:0] MOST_POS   = 32'h7FFF_FFFF;
  localparam longint      MOST_POS_L = 64'sd2147483647;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          DRAIN_CYCLES = 60;
  localparam int          REPORT_LIMIT = 10;

  // One predicted result: value and range error flag
  typedef struct packed {
    logic [31:0] value;
    logic        range_err;
  } ranged_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  // Generator copy kept in step with the block
  logic [31:0] gen_x = SEED_X;
  logic [31:0] gen_y = SEED_Y;
  logic [31:0] gen_z = SEED_Z;

  ranged_result_t pending_results[$];
  int  fail_count  = 0;
  int  cycle_count = 0;
  int  ready_stall = 0;
  bit  idle_en     = 1'b1;

  xorshift96_ranged_random_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the generator and fold the new word into the requested range
  function automatic ranged_result_t draw_ranged_value(input logic [31:0] lo,
                                                       input logic [31:0] hi);
    logic [31:0]    s;
    logic [63:0]    span;
    logic [63:0]    rem;
    ranged_result_t res;
    s = gen_x;
    s = s ^ (s << 16);
    s = s ^ (s >> 5);
    s = s ^ (s << 1);
    gen_x = gen_y;
    gen_y = gen_z;
    gen_z = s ^ gen_x ^ gen_y;
    if ($signed(hi) < $signed(lo)) begin
      res.range_err = 1'b1;
      res.value     = lo;
    end else begin
      span = 64'(longint'($signed(hi)) - longint'($signed(lo)) + 64'sd1);
      rem  = {32'd0, gen_z} % span;
      res.range_err = 1'b0;
      res.value     = rem[31:0] + lo;
    end
    return res;
  endfunction

  // Offer one item, hold it until accepted, then record its expected result
  task automatic send_bounds(input logic [31:0] lo, input logic [31:0] hi);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tdata  = {hi, lo};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(draw_ranged_value(lo, hi));
    @(negedge clk);
  endtask

  // Extremes, equal bounds, full range and inverted bounds
  task automatic run_directed_bounds();
    send_bounds(32'd0, 32'd0);
    send_bounds(MOST_NEG, MOST_NEG);
    send_bounds(MOST_POS, MOST_POS);
    send_bounds(MOST_NEG, MOST_POS);
    send_bounds(MOST_NEG, MOST_POS);
    send_bounds(MOST_POS, MOST_NEG);
    send_bounds(32'd0, 32'hFFFF_FFFF);
    send_bounds(32'd1, 32'd0);
    send_bounds(32'd0, MOST_POS);
    send_bounds(MOST_NEG, 32'hFFFF_FFFF);
    send_bounds(MOST_NEG, 32'd0);
    send_bounds(32'hFFFF_FFFF, 32'd0);
    send_bounds(32'd0, 32'd1);
    send_bounds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_bounds(MOST_POS - 32'd9, MOST_POS);
    send_bounds(MOST_NEG, MOST_NEG + 32'd6);
    send_bounds(32'hFFFF_FFF0, 32'h0000_000F);
    send_bounds(MOST_POS, 32'hFFFF_FFFF);
  endtask

  // Random bounds: mostly ordered ranges of varied span, some inverted or raw
  task automatic run_random_bounds(input int count);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] tmp;
    logic [31:0] picks[5];
    longint      hi_l;
    longint      delta;
    int          kind;
    picks = '{MOST_NEG, 32'hFFFF_FFFF, 32'd0, 32'd1, MOST_POS};
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      lo = $urandom();
      hi = $urandom();
      case (kind)
        0, 1, 2, 3: begin
          if ($signed(hi) < $signed(lo)) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
        end
        4, 5, 6: begin
          if (kind == 6) delta = (64'sd1 <<< $urandom_range(0, 32)) - 64'sd1;
          else delta = longint'($urandom_range(0, 255));
          hi_l = longint'($signed(lo)) + delta;
          if (hi_l > MOST_POS_L) hi_l = MOST_POS_L;
          hi = hi_l[31:0];
        end
        7: begin
          if ($signed(hi) > $signed(lo)) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end else if (hi == lo) begin
            hi = (lo == MOST_NEG) ? MOST_POS : lo - 32'd1;
            if (lo == MOST_NEG) lo = MOST_POS;
          end
        end
        8: begin
          lo = picks[$urandom_range(0, 4)];
          hi = picks[$urandom_range(0, 4)];
        end
        default: begin
        end
      endcase
      send_bounds(lo, hi);
    end
  endtask

  // Back-to-back stream with both sides always ready
  task automatic run_steady_stream(input int count);
    idle_en = 1'b0;
    run_random_bounds(count);
  endtask

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (ready_stall > 0) begin
      ready_stall--;
      out_tready = 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      ready_stall = $urandom_range(1, 19) - 1;
      out_tready  = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    ranged_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: value=%h range_error=%b", out_tdata, out_tuser);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.value || out_tuser !== want.range_err) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch: value exp=%h got=%h, range_error exp=%b got=%b",
                     want.value, out_tdata, want.range_err, out_tuser);
        end
      end
    end
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("xorshift96_ranged_random_top_tb failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    run_directed_bounds();
    run_random_bounds(1300);
    run_steady_stream(200);
    in_tvalid = 1'b0;
    // Drain outstanding results, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("xorshift96_ranged_random_top_tb passed");
    else
      $display("xorshift96_ranged_random_top_tb failed");
    $finish;
  end

endmodule
`default_nettype wire

### files.f
src/xs96_pkg.sv
src/xs96_front.sv
src/xs96_fifo.sv
src/xs96_back.sv
src/xorshift96_ranged_random_top.sv
sim/xorshift96_ranged_random_top_tb.sv
